// File: sv/spmfq_pkg.sv
package spmfq_pkg;

   // field widths of the two channels
   localparam int VALUE_W      = 32;
   localparam int REQ_LEVEL_W  = 32;
   localparam int LEVEL_OUT_W  = 5;
   localparam int REQ_DATA_W   = VALUE_W + REQ_LEVEL_W;
   localparam int RSP_FIELDS_W = LEVEL_OUT_W + VALUE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int REQ_USER_W   = 1;
   localparam int RSP_USER_W   = 2;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ_READ,
      S_FINISH
   } state_type;

endpackage

// File: sv/spmfq_ram.sv
module spmfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/strict_priority_multi_fifo_queue_unit.sv
// Strict priority queue, level 0 highest, first-in first-out within a level.
// Request channel (req_): tuser carries the action (enqueue or dequeue), tdata
// the value and the requested level; a level outside the range goes to the
// lowest-priority level, LEVELS-1. Each request gives exactly one response on rsp_: tuser the
// status, tdata the value and the level used or served.
// All levels share one pool of CAPACITY slots held in a value memory and a
// link memory; a level table memory holds head and tail per level, and
// non-empty bits live in flip-flops.
// An enqueue, a rejected enqueue or a dequeue from an empty queue reads the
// level table and then registers its response on rsp_; a dequeue that finds
// an item reads the level table and then the slot memories at the head
// before its response is registered. The next request is taken in the cycle
// after the response is registered, so a new request is never taken before
// the last one has finished.
// Reset empties every level and chains the free list in slot order without a
// clearing pass: slots never allocated are tracked by a fill count.
// A stalled response holds in the output register; a new request is still
// taken, but its response waits until the previous one has been transferred.
module strict_priority_multi_fifo_queue_unit #(
   parameter int CAPACITY = 256,
   parameter int LEVELS   = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] action
   input  logic [spmfq_pkg::REQ_USER_W-1:0]   req_tuser,
   // [31:0] item_value, [63:32] requested_level
   input  logic [spmfq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] status
   output logic [spmfq_pkg::RSP_USER_W-1:0]   rsp_tuser,
   // [31:0] out_value, [36:32] out_level, rest zero
   output logic [spmfq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import spmfq_pkg::*;

   localparam int PW = $clog2(CAPACITY);
   localparam int LW = $clog2(LEVELS);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LAST_LEVEL = LEVELS - 1;

   state_type         state_ff, state_in;
   logic              op_deq_ff;
   logic              hit_ff;
   logic [LW-1:0]     lvl_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [PW-1:0]     rd_slot_ff;
   logic [LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [PW-1:0]     free_head_ff, free_head_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     fresh_ff, fresh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [LEVEL_OUT_W-1:0] rsp_level_ff;

   logic                     accept;
   logic                     out_load;
   logic                     req_action;
   logic [VALUE_W-1:0]       req_value;
   logic signed [REQ_LEVEL_W-1:0] req_level_raw;
   logic [LW-1:0]            mapped_lvl;
   logic                     top_found;
   logic [LW-1:0]            top_lvl;

   logic [LW-1:0]     level_raddr;
   logic [2*PW-1:0]   level_rd;
   logic              level_we;
   logic [2*PW-1:0]   level_wdata;
   logic [PW-1:0]     head_rd, tail_rd;
   logic [PW-1:0]     slot_raddr;
   logic [PW-1:0]     link_rd;
   logic              link_we;
   logic [PW-1:0]     link_waddr, link_wdata;
   logic [VALUE_W-1:0] value_rd;
   logic              value_we;
   logic              virgin;
   logic [PW-1:0]     next_seq;
   logic [PW-1:0]     link_next;
   logic              cur_nonempty;

   assign req_action    = req_tuser[0];
   assign req_value     = req_tdata[VALUE_W-1:0];
   assign req_level_raw = $signed(req_tdata[REQ_DATA_W-1:VALUE_W]);

   always_comb begin
      if (req_level_raw < 0 || req_level_raw > LAST_LEVEL) begin
         mapped_lvl = LW'(LAST_LEVEL);
      end else begin
         mapped_lvl = LW'(req_level_raw);
      end
   end

   // lowest-numbered non-empty level
   always_comb begin
      top_found = 1'b0;
      top_lvl   = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            top_found = 1'b1;
            top_lvl   = LW'(i);
         end
      end
   end

   assign head_rd      = level_rd[2*PW-1:PW];
   assign tail_rd      = level_rd[PW-1:0];
   assign cur_nonempty = nonempty_ff[lvl_ff];

   // slots at or above the fill count were never allocated and still link in order
   assign virgin    = CW'(rd_slot_ff) >= fresh_ff;
   assign next_seq  = (rd_slot_ff == PW'(CAPACITY - 1)) ? '0 : rd_slot_ff + PW'(1);
   assign link_next = virgin ? next_seq : link_rd;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_action == ACT_DEQUEUE && top_found) ? S_DEQ_READ : S_FINISH;
            end
         end
         S_DEQ_READ: state_in = S_FINISH;
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // handshake and memory addressing
   always_comb begin
      req_tready  = 1'b0;
      out_load    = 1'b0;
      level_raddr = lvl_ff;
      slot_raddr  = rd_slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            level_raddr = (req_action == ACT_DEQUEUE) ? top_lvl : mapped_lvl;
            slot_raddr  = free_head_ff;
         end
         S_DEQ_READ: slot_raddr = head_rd;
         S_FINISH:   out_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // memory writes and pointer updates when an item completes
   always_comb begin
      level_we     = 1'b0;
      level_wdata  = {head_rd, tail_rd};
      link_we      = 1'b0;
      link_waddr   = rd_slot_ff;
      link_wdata   = free_head_ff;
      value_we     = 1'b0;
      nonempty_in  = nonempty_ff;
      free_head_in = free_head_ff;
      used_in      = used_ff;
      fresh_in     = fresh_ff;
      if (out_load && hit_ff) begin
         if (!op_deq_ff) begin
            value_we    = 1'b1;
            level_we    = 1'b1;
            level_wdata = {cur_nonempty ? head_rd : rd_slot_ff, rd_slot_ff};
            link_we     = cur_nonempty;
            link_waddr  = tail_rd;
            link_wdata  = rd_slot_ff;
            nonempty_in[lvl_ff] = 1'b1;
            free_head_in = link_next;
            used_in      = used_ff + CW'(1);
            if (virgin) begin
               fresh_in = fresh_ff + CW'(1);
            end
         end else begin
            if (rd_slot_ff == tail_rd) begin
               nonempty_in[lvl_ff] = 1'b0;
            end else begin
               level_we    = 1'b1;
               level_wdata = {link_rd, tail_rd};
            end
            link_we      = 1'b1;
            link_waddr   = rd_slot_ff;
            link_wdata   = free_head_ff;
            free_head_in = rd_slot_ff;
            used_in      = used_ff - CW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nonempty_ff  <= '0;
         free_head_ff <= '0;
         used_ff      <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         free_head_ff <= free_head_in;
         used_ff      <= used_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_deq_ff  <= req_action;
         hit_ff     <= (req_action == ACT_DEQUEUE) ? top_found
                                                   : (used_ff != CW'(CAPACITY));
         lvl_ff     <= (req_action == ACT_DEQUEUE) ? top_lvl : mapped_lvl;
         value_ff   <= req_value;
         rd_slot_ff <= free_head_ff;
      end else if (state_ff == S_DEQ_READ) begin
         rd_slot_ff <= head_rd;
      end
      if (out_load) begin
         if (op_deq_ff) begin
            rsp_status_ff <= hit_ff ? ST_DEQUEUED : ST_EMPTY;
            rsp_value_ff  <= hit_ff ? value_rd : '0;
            rsp_level_ff  <= hit_ff ? LEVEL_OUT_W'(lvl_ff) : '0;
         end else begin
            rsp_status_ff <= hit_ff ? ST_ENQUEUED : ST_FULL;
            rsp_value_ff  <= value_ff;
            rsp_level_ff  <= LEVEL_OUT_W'(lvl_ff);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_level_ff, rsp_value_ff};

   spmfq_ram #(.WIDTH(2 * PW), .DEPTH(LEVELS)) u_level_ram (
      .clock   (clock),
      .wr_en   (level_we),
      .wr_addr (lvl_ff),
      .wr_data (level_wdata),
      .rd_addr (level_raddr),
      .rd_data (level_rd)
   );

   spmfq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (slot_raddr),
      .rd_data (link_rd)
   );

   spmfq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (rd_slot_ff),
      .wr_data (value_ff),
      .rd_addr (slot_raddr),
      .rd_data (value_rd)
   );

   // every allocated slot sits in some level
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) == (nonempty_ff != '0))
      else $error("occupancy and non-empty bits disagree");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      fresh_ff >= used_ff)
      else $error("fill count below occupancy");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (out_load && hit_ff && !op_deq_ff) |=> used_ff == CW'($past(used_ff) + CW'(1)))
      else $error("enqueue did not take a slot");

   a_deq_level: assert property (@(posedge clock) disable iff (reset)
      (out_load && hit_ff && op_deq_ff) |-> cur_nonempty)
      else $error("dequeue served an empty level");

endmodule
